[rtl/core/key_value_map_table_defines.svh]
// assertion macros shared by the key-value map table modules
// no dependencies; included by the files that carry assertions
`ifndef KEY_VALUE_MAP_TABLE_DEFINES_SVH
`define KEY_VALUE_MAP_TABLE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define KVMT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define KVMT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/kvmt_pkg.sv]
// codes, reset values and controller/datapath interface structs
// for the key-value map table; no dependencies
package kvmt_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_KIND    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_BYTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT = 2'd3;

  localparam logic [3:0] RST_KEY_BYTES   = 4'd4;
  localparam logic [3:0] RST_VALUE_BYTES = 4'd8;
  localparam logic [6:0] RST_ENTRY_LIMIT = 7'd64;

  // request actions
  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_UPDATE = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_NEXT   = 2'd3;

  // result status
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_INVALID   = 2'd3;

  // store write kinds
  localparam logic [2:0] WR_NONE   = 3'd0;
  localparam logic [2:0] WR_UPDATE = 3'd1;
  localparam logic [2:0] WR_INSERT = 3'd2;
  localparam logic [2:0] WR_DELETE = 3'd3;
  localparam logic [2:0] WR_ARRAY  = 3'd4;
  localparam logic [2:0] WR_CLEAR  = 3'd5;

  // result payload sources
  localparam logic [2:0] SRC_NONE      = 3'd0;
  localparam logic [2:0] SRC_RD_VALUE  = 3'd1;
  localparam logic [2:0] SRC_RD_KEY    = 3'd2;
  localparam logic [2:0] SRC_FIRST_KEY = 3'd3;
  localparam logic [2:0] SRC_ARRAY_KEY = 3'd4;

  typedef struct packed {
    logic       load_req;
    logic       scan;
    logic       clr_run;
    logic       clr_restart;
    logic       arr_read;
    logic [2:0] wr_kind;
    logic       res_load;
    logic [1:0] res_status;
    logic [2:0] res_src;
    logic       out_load;
  } kvmt_cmd_t;

  typedef struct packed {
    logic       is_array;
    logic [1:0] action;
    logic       aidx_ok;
    logic       arr_next_ok;
    logic       ev_match;
    logic       ev_next_hit;
    logic       scan_end;
    logic       free_ok;
    logic       matched;
    logic       first_ok;
    logic       clr_last;
  } kvmt_stat_t;

endpackage

[rtl/core/kvmt_dpath.sv]
// datapath of the key-value map table: config registers, slot store,
// slot walk trackers, result and output registers; uses kvmt_pkg
`include "key_value_map_table_defines.svh"

module kvmt_dpath import kvmt_pkg::*; #(
  parameter int SLOTS       = 64,
  parameter int KEY_BYTES   = 8,
  parameter int VALUE_BYTES = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [1:0]               in_action,
  input  logic [8*KEY_BYTES-1:0]   in_key,
  input  logic                     in_key_given,
  input  logic [8*VALUE_BYTES-1:0] in_new_value,
  input  kvmt_cmd_t                cmd,
  output kvmt_stat_t               st,
  output logic [1:0]               out_status,
  output logic [8*VALUE_BYTES-1:0] out_found_value,
  output logic [8*KEY_BYTES-1:0]   out_following_key
);

  localparam int KW = 8 * KEY_BYTES;
  localparam int VW = 8 * VALUE_BYTES;
  localparam int AW = $clog2(SLOTS);
  localparam int LW = AW + 1;
  localparam int IW = (KW < 32) ? KW : 32;
  localparam int CW = (IW > LW) ? IW : LW;

  // configuration
  logic          map_kind_r;
  logic [3:0]    key_bytes_r;
  logic [3:0]    value_bytes_r;
  logic [6:0]    entry_limit_r;
  logic [3:0]    kb;
  logic [3:0]    vb;
  logic [KW-1:0] kmask;
  logic [KW-1:0] imask;
  logic [VW-1:0] vmask;
  logic [LW+6:0] el_ext;
  logic [LW-1:0] lim;

  // request
  logic [1:0]    action_r;
  logic [KW-1:0] key_r;
  logic          key_given_r;
  logic [VW-1:0] nv_r;

  // array addressing
  logic [IW-1:0]    aidx;
  logic [CW+IW-1:0] aidx_ext;
  logic [CW+LW-1:0] lim_cw;
  logic             aidx_ok;
  logic [AW-1:0]    aidx_slot;
  logic [LW-1:0]    arr_start;
  logic [KW+LW-1:0] start_ext;
  logic [KW-1:0]    arr_key;

  // slot store
  logic          valid_mem [SLOTS];
  logic [KW-1:0] key_mem   [SLOTS];
  logic [VW-1:0] val_mem   [SLOTS];
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          valid_we;
  logic          key_we;
  logic          val_we;
  logic          wvalid;
  logic [KW-1:0] wkey;
  logic [VW-1:0] wval;
  logic          rd_valid_r;
  logic [KW-1:0] rd_key_r;
  logic [VW-1:0] rd_val_r;

  // walk trackers
  logic [LW-1:0] scan_r, scan_nxt;
  logic          rd_live_r, rd_live_nxt;
  logic [AW-1:0] rd_idx_r;
  logic          free_ok_r, free_ok_nxt;
  logic [AW-1:0] free_idx_r;
  logic          matched_r, matched_nxt;
  logic          first_ok_r, first_ok_nxt;
  logic [KW-1:0] first_key_r;
  logic [AW-1:0] clr_r, clr_nxt;
  logic          clr_last;
  logic          issue;
  logic          key_eq;
  logic          ev_match;

  // result
  logic [1:0]    res_status_r;
  logic [VW-1:0] res_fval_r;
  logic [KW-1:0] res_fkey_r;
  logic [VW-1:0] fval_sel;
  logic [KW-1:0] fkey_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_kind_r    <= 1'b0;
      key_bytes_r   <= RST_KEY_BYTES;
      value_bytes_r <= RST_VALUE_BYTES;
      entry_limit_r <= RST_ENTRY_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAP_KIND:    map_kind_r    <= cfg_wdata[0];
        CFG_KEY_BYTES:   key_bytes_r   <= cfg_wdata[3:0];
        CFG_VALUE_BYTES: value_bytes_r <= cfg_wdata[3:0];
        CFG_ENTRY_LIMIT: entry_limit_r <= cfg_wdata;
      endcase
    end
  end

  // effective widths and limit, out-of-range settings clamp
  assign el_ext = {{LW{1'b0}}, entry_limit_r};

  always_comb begin
    kb = key_bytes_r;
    if (key_bytes_r == 4'd0) begin
      kb = 4'd1;
    end else if (key_bytes_r > 4'(KEY_BYTES)) begin
      kb = 4'(KEY_BYTES);
    end
    vb = value_bytes_r;
    if (value_bytes_r == 4'd0) begin
      vb = 4'd1;
    end else if (value_bytes_r > 4'(VALUE_BYTES)) begin
      vb = 4'(VALUE_BYTES);
    end
    for (int b = 0; b < KEY_BYTES; b++) begin
      kmask[8*b +: 8] = {8{4'(b) < kb}};
      imask[8*b +: 8] = {8{(4'(b) < kb) && (b < 4)}};
    end
    for (int b = 0; b < VALUE_BYTES; b++) begin
      vmask[8*b +: 8] = {8{4'(b) < vb}};
    end
    if (entry_limit_r == 7'd0) begin
      lim = LW'(1);
    end else if (int'(entry_limit_r) > SLOTS) begin
      lim = LW'(SLOTS);
    end else begin
      lim = el_ext[LW-1:0];
    end
  end

  // array mode: slot index straight from the low key bytes
  assign aidx      = key_r[IW-1:0] & imask[IW-1:0];
  assign aidx_ext  = {{CW{1'b0}}, aidx};
  assign lim_cw    = {{CW{1'b0}}, lim};
  assign aidx_ok   = aidx_ext[CW-1:0] < lim_cw[CW-1:0];
  assign aidx_slot = aidx_ext[AW-1:0];
  assign arr_start = (key_given_r && aidx_ok) ? ({1'b0, aidx_slot} + LW'(1)) : '0;
  assign start_ext = {{KW{1'b0}}, arr_start};
  assign arr_key   = start_ext[KW-1:0] & imask;

  // store write port
  always_comb begin
    waddr    = '0;
    valid_we = 1'b0;
    key_we   = 1'b0;
    val_we   = 1'b0;
    wvalid   = 1'b0;
    wkey     = key_r & kmask;
    wval     = '0;
    case (cmd.wr_kind)
      WR_UPDATE: begin
        val_we = 1'b1;
        waddr  = rd_idx_r;
        wval   = nv_r;
      end
      WR_INSERT: begin
        val_we   = 1'b1;
        valid_we = 1'b1;
        key_we   = 1'b1;
        waddr    = free_idx_r;
        wvalid   = 1'b1;
        wval     = nv_r;
      end
      WR_DELETE: begin
        val_we   = 1'b1;
        valid_we = 1'b1;
        waddr    = rd_idx_r;
      end
      WR_ARRAY: begin
        val_we = 1'b1;
        waddr  = aidx_slot;
        wval   = nv_r;
      end
      WR_CLEAR: begin
        val_we   = 1'b1;
        valid_we = 1'b1;
        waddr    = clr_r;
      end
      default: begin
      end
    endcase
  end

  assign issue = cmd.scan && (scan_r < lim);
  assign raddr = cmd.arr_read ? aidx_slot : scan_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (valid_we) begin
      valid_mem[waddr] <= wvalid;
    end
    if (key_we) begin
      key_mem[waddr] <= wkey;
    end
    if (val_we) begin
      val_mem[waddr] <= wval;
    end
    rd_valid_r <= valid_mem[raddr];
    rd_key_r   <= key_mem[raddr];
    rd_val_r   <= val_mem[raddr];
  end

  // evaluate the word from the registered store read
  assign key_eq   = ((rd_key_r ^ key_r) & kmask) == '0;
  assign ev_match = rd_live_r && rd_valid_r && key_eq;
  assign clr_last = clr_r == AW'(SLOTS - 1);

  always_comb begin
    scan_nxt     = scan_r;
    free_ok_nxt  = free_ok_r;
    matched_nxt  = matched_r;
    first_ok_nxt = first_ok_r;
    clr_nxt      = clr_r;
    rd_live_nxt  = issue;
    if (cmd.load_req || cmd.clr_restart) begin
      scan_nxt     = '0;
      free_ok_nxt  = 1'b0;
      matched_nxt  = 1'b0;
      first_ok_nxt = 1'b0;
    end else if (cmd.scan) begin
      if (issue) begin
        scan_nxt = scan_r + LW'(1);
      end
      if (rd_live_r && !rd_valid_r) begin
        free_ok_nxt = 1'b1;
      end
      if (ev_match) begin
        matched_nxt = 1'b1;
      end
      if (rd_live_r && rd_valid_r) begin
        first_ok_nxt = 1'b1;
      end
    end
    if (cmd.clr_restart) begin
      clr_nxt = '0;
    end else if (cmd.clr_run) begin
      clr_nxt = clr_last ? '0 : clr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r     <= '0;
      rd_live_r  <= 1'b0;
      free_ok_r  <= 1'b0;
      matched_r  <= 1'b0;
      first_ok_r <= 1'b0;
      clr_r      <= '0;
    end else begin
      scan_r     <= scan_nxt;
      rd_live_r  <= rd_live_nxt;
      free_ok_r  <= free_ok_nxt;
      matched_r  <= matched_nxt;
      first_ok_r <= first_ok_nxt;
      clr_r      <= clr_nxt;
    end
  end

  always_comb begin
    fval_sel = '0;
    fkey_sel = '0;
    case (cmd.res_src)
      SRC_RD_VALUE:  fval_sel = rd_val_r & vmask;
      SRC_RD_KEY:    fkey_sel = rd_key_r & kmask;
      SRC_FIRST_KEY: fkey_sel = first_key_r;
      SRC_ARRAY_KEY: fkey_sel = arr_key;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= scan_r[AW-1:0];
    if (cmd.scan && rd_live_r && !rd_valid_r && !free_ok_r) begin
      free_idx_r <= rd_idx_r;
    end
    if (cmd.scan && rd_live_r && rd_valid_r && !first_ok_r) begin
      first_key_r <= rd_key_r & kmask;
    end
    if (cmd.load_req) begin
      action_r    <= in_action;
      key_r       <= in_key;
      key_given_r <= in_key_given;
      nv_r        <= in_new_value & vmask;
    end
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      res_fval_r   <= fval_sel;
      res_fkey_r   <= fkey_sel;
    end
    if (cmd.out_load) begin
      out_status        <= res_status_r;
      out_found_value   <= res_fval_r;
      out_following_key <= res_fkey_r;
    end
  end

  assign st.is_array    = map_kind_r;
  assign st.action      = action_r;
  assign st.aidx_ok     = aidx_ok;
  assign st.arr_next_ok = arr_start < lim;
  assign st.ev_match    = ev_match;
  assign st.ev_next_hit = rd_live_r && rd_valid_r && (!key_given_r || matched_r);
  assign st.scan_end    = (scan_r == lim) && !rd_live_r;
  assign st.free_ok     = free_ok_r;
  assign st.matched     = matched_r;
  assign st.first_ok    = first_ok_r;
  assign st.clr_last    = clr_last;

  `KVMT_ASSERT_IMP(a_insert_has_free, clk, rst_n, cmd.wr_kind == WR_INSERT, free_ok_r,
    "insert issued without a free slot")
  `KVMT_ASSERT_IMP(a_free_below_limit, clk, rst_n, free_ok_r, LW'(free_idx_r) < lim,
    "free slot at or above entry limit")

endmodule

[rtl/core/kvmt_ctrl.sv]
// controller of the key-value map table: sequences clearing, slot walks,
// store writes and result hand-off; uses kvmt_pkg
`include "key_value_map_table_defines.svh"

module kvmt_ctrl import kvmt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  kvmt_stat_t st,
  output kvmt_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_AREAD = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.wr_kind = WR_CLEAR;
        cmd.clr_run = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_START;
        end
      end
      S_START: begin
        if (!st.is_array) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt      = S_OUT;
          cmd.res_load   = 1'b1;
          cmd.res_status = STAT_NOT_FOUND;
          unique case (st.action)
            ACT_LOOKUP: begin
              if (st.aidx_ok) begin
                cmd.arr_read = 1'b1;
                cmd.res_load = 1'b0;
                state_nxt    = S_AREAD;
              end
            end
            ACT_UPDATE: begin
              if (st.aidx_ok) begin
                cmd.wr_kind    = WR_ARRAY;
                cmd.res_status = STAT_OK;
              end
            end
            ACT_DELETE: cmd.res_status = STAT_INVALID;
            ACT_NEXT: begin
              if (st.arr_next_ok) begin
                cmd.res_status = STAT_OK;
                cmd.res_src    = SRC_ARRAY_KEY;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        unique case (st.action)
          ACT_LOOKUP: begin
            if (st.ev_match) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = STAT_OK;
              cmd.res_src    = SRC_RD_VALUE;
            end else if (st.scan_end) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = STAT_NOT_FOUND;
            end
          end
          ACT_UPDATE: begin
            if (st.ev_match) begin
              cmd.wr_kind    = WR_UPDATE;
              cmd.res_load   = 1'b1;
              cmd.res_status = STAT_OK;
            end else if (st.scan_end) begin
              cmd.res_load = 1'b1;
              if (st.free_ok) begin
                cmd.wr_kind    = WR_INSERT;
                cmd.res_status = STAT_OK;
              end else begin
                cmd.res_status = STAT_FULL;
              end
            end
          end
          ACT_DELETE: begin
            if (st.ev_match) begin
              cmd.wr_kind    = WR_DELETE;
              cmd.res_load   = 1'b1;
              cmd.res_status = STAT_OK;
            end else if (st.scan_end) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = STAT_NOT_FOUND;
            end
          end
          ACT_NEXT: begin
            if (st.ev_next_hit) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = STAT_OK;
              cmd.res_src    = SRC_RD_KEY;
            end else if (st.scan_end) begin
              // given key absent: fall back to the first valid slot
              cmd.res_load = 1'b1;
              if (!st.matched && st.first_ok) begin
                cmd.res_status = STAT_OK;
                cmd.res_src    = SRC_FIRST_KEY;
              end else begin
                cmd.res_status = STAT_NOT_FOUND;
              end
            end
          end
        endcase
        if (cmd.res_load) begin
          state_nxt = S_OUT;
        end
      end
      S_AREAD: begin
        cmd.res_load   = 1'b1;
        cmd.res_status = STAT_OK;
        cmd.res_src    = SRC_RD_VALUE;
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
    // any config write wipes the store
    if (cfg_we) begin
      cmd             = '0;
      cmd.clr_restart = 1'b1;
      state_nxt       = S_CLEAR;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `KVMT_ASSERT_IMP(a_no_out_overwrite, clk, rst_n, cmd.out_load, !out_valid_r || out_ready,
    "output word overwritten before it was taken")
  `KVMT_ASSERT_NXT(a_cfg_clears, clk, rst_n, cfg_we, state_r == S_CLEAR,
    "config write did not start a clearing pass")
  `KVMT_ASSERT_NXT(a_accept_starts, clk, rst_n, in_valid && in_ready && !cfg_we,
    state_r == S_START, "accepted word did not start processing")

endmodule

[rtl/core/key_value_map_table.sv]
// top level of the key-value map table: wires controller and datapath
// depends on kvmt_pkg, kvmt_ctrl and kvmt_dpath
//
// One map of SLOTS entries, hash mode (key search) or array mode (key is the
// slot index), taking one request word at a time and giving one result word.
// A hash request walks slots 0 .. limit-1 through the single store read port,
// one slot per cycle, until a hit ends the walk early; an array request needs
// no walk. After reset and after every config write a clearing pass writes
// SLOTS entries, one per cycle, with in_ready low; config writes are still
// taken then and restart the pass. A finished result waits in the output
// register while the next request is accepted.
module key_value_map_table import kvmt_pkg::*; #(
  parameter int SLOTS       = 64,
  parameter int KEY_BYTES   = 8,
  parameter int VALUE_BYTES = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_action,
  input  logic [8*KEY_BYTES-1:0]   in_key,
  input  logic                     in_key_given,
  input  logic [8*VALUE_BYTES-1:0] in_new_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic [8*VALUE_BYTES-1:0] out_found_value,
  output logic [8*KEY_BYTES-1:0]   out_following_key,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

  kvmt_cmd_t  cmd;
  kvmt_stat_t st;

  kvmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  kvmt_dpath #(
    .SLOTS       (SLOTS),
    .KEY_BYTES   (KEY_BYTES),
    .VALUE_BYTES (VALUE_BYTES)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_action         (in_action),
    .in_key            (in_key),
    .in_key_given      (in_key_given),
    .in_new_value      (in_new_value),
    .cmd               (cmd),
    .st                (st),
    .out_status        (out_status),
    .out_found_value   (out_found_value),
    .out_following_key (out_following_key)
  );

endmodule

[tb/sv/testbench.sv]
// self-checking testbench for key_value_map_table: directed and random request words,
// each reply checked against a shadow copy of the map store kept here
// depends on kvmt_pkg and the key_value_map_table rtl
module testbench;
  import kvmt_pkg::*;

  localparam int NSLOT = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 80;
  localparam logic KIND_HASH = 1'b0;
  localparam logic KIND_ARRAY = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] key;
    logic        key_given;
    logic [63:0] new_value;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] found_value;
    logic [63:0] following_key;
  } reply_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_action = ACT_LOOKUP;
  logic [63:0]           in_key = '0;
  logic                  in_key_given = 1'b0;
  logic [63:0]           in_new_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic [1:0]            out_status;
  logic [63:0]           out_found_value;
  logic [63:0]           out_following_key;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_MAP_KIND;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow of the store and of the registers
  bit        shadow_used [NSLOT];
  bit [63:0] shadow_key [NSLOT];
  bit [63:0] shadow_val [NSLOT];
  bit        cur_kind;
  bit [3:0]  cur_kbytes;
  bit [3:0]  cur_vbytes;
  bit [6:0]  cur_limit;

  reply_t      pending_replies[$];
  bit          idle_on = 1'b1;
  logic [63:0] last_following = '0;
  int          items_sent = 0;
  int          replies_checked = 0;
  int          config_writes = 0;
  int          mismatches = 0;
  int          status_seen [4] = '{0, 0, 0, 0};

  key_value_map_table dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_key            (in_key),
    .in_key_given      (in_key_given),
    .in_new_value      (in_new_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_found_value   (out_found_value),
    .out_following_key (out_following_key),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int clamp_to(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [63:0] low_bytes_mask(int n);
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic int key_width();
    return clamp_to(int'(cur_kbytes), 1, 8);
  endfunction

  function automatic int value_width();
    return clamp_to(int'(cur_vbytes), 1, 8);
  endfunction

  function automatic int slot_limit();
    return clamp_to(int'(cur_limit), 1, NSLOT);
  endfunction

  // array index comes from at most four low key bytes
  function automatic logic [63:0] index_mask();
    return low_bytes_mask(key_width() < 4 ? key_width() : 4);
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic void wipe_store();
    int i;
    for (i = 0; i < NSLOT; i++) begin
      shadow_used[i] = 1'b0;
      shadow_key[i] = '0;
      shadow_val[i] = '0;
    end
    if (cur_kind == KIND_ARRAY) begin
      for (i = 0; i < slot_limit(); i++) begin
        shadow_used[i] = 1'b1;
        shadow_key[i] = 64'(i) & index_mask();
      end
    end
  endfunction

  function automatic int locate_slot(logic [63:0] key);
    logic [63:0] kmask;
    logic [63:0] slot_idx;
    int i;
    kmask = low_bytes_mask(key_width());
    if (cur_kind == KIND_ARRAY) begin
      slot_idx = key & index_mask();
      if (slot_idx >= 64'(slot_limit())) return -1;
      return int'(slot_idx);
    end
    for (i = 0; i < NSLOT; i++)
      if (shadow_used[i] && ((shadow_key[i] ^ key) & kmask) == 64'd0) return i;
    return -1;
  endfunction

  // applies one request to the shadow store and returns the reply it gives
  function automatic reply_t predict_reply(request_t rq);
    reply_t      rp;
    logic [63:0] vmask;
    logic [63:0] kmask;
    int          idx;
    int          start;
    int          i;
    rp = '0;
    vmask = low_bytes_mask(value_width());
    kmask = low_bytes_mask(key_width());
    case (rq.action)
      ACT_LOOKUP: begin
        idx = locate_slot(rq.key);
        if (idx < 0 || !shadow_used[idx]) rp.status = STAT_NOT_FOUND;
        else rp.found_value = shadow_val[idx] & vmask;
      end
      ACT_UPDATE: begin
        idx = locate_slot(rq.key);
        if (idx < 0 && cur_kind == KIND_ARRAY) begin
          rp.status = STAT_NOT_FOUND;
        end else if (idx < 0) begin
          // new key goes to the lowest free slot below the limit
          for (i = slot_limit() - 1; i >= 0; i--)
            if (!shadow_used[i]) idx = i;
          if (idx < 0) begin
            rp.status = STAT_FULL;
          end else begin
            shadow_used[idx] = 1'b1;
            shadow_key[idx] = rq.key & kmask;
          end
        end
        if (idx >= 0) shadow_val[idx] = rq.new_value & vmask;
      end
      ACT_DELETE: begin
        if (cur_kind == KIND_ARRAY) begin
          rp.status = STAT_INVALID;
        end else begin
          idx = locate_slot(rq.key);
          if (idx < 0) begin
            rp.status = STAT_NOT_FOUND;
          end else begin
            shadow_used[idx] = 1'b0;
            shadow_key[idx] = '0;
            shadow_val[idx] = '0;
          end
        end
      end
      ACT_NEXT: begin
        start = 0;
        if (rq.key_given) begin
          idx = locate_slot(rq.key);
          if (idx >= 0) start = idx + 1;
        end
        rp.status = STAT_NOT_FOUND;
        // walk down so the lowest valid slot at or above start wins
        for (i = slot_limit() - 1; i >= start; i--)
          if (shadow_used[i]) begin
            rp.status = STAT_OK;
            rp.following_key = shadow_key[i] & kmask;
          end
      end
    endcase
    return rp;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("mismatch %0d at reply %0d: %s got %h want %h",
             mismatches, replies_checked, what, got, want);
  endtask

  // valid stays high across back-to-back words; send_request lowers it only when a gap starts
  task automatic send_request(logic [1:0] act, logic [63:0] key, logic kg, logic [63:0] nv);
    request_t rq;
    reply_t   rp;
    int       gap;
    rq = '{action: act, key: key, key_given: kg, new_value: nv};
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_key <= key;
    in_key_given <= kg;
    in_new_value <= nv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rp = predict_reply(rq);
    if (act == ACT_NEXT && rp.status == STAT_OK) last_following = rp.following_key;
    pending_replies.push_back(rp);
    items_sent++;
  endtask

  task automatic wait_idle();
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // cfg_we is left high between the writes of one set_config
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_MAP_KIND:    cur_kind = data[0];
      CFG_KEY_BYTES:   cur_kbytes = data[3:0];
      CFG_VALUE_BYTES: cur_vbytes = data[3:0];
      CFG_ENTRY_LIMIT: cur_limit = data[6:0];
    endcase
    wipe_store();
    @(posedge clk);
    config_writes++;
  endtask

  task automatic set_config(logic kind, int kb, int vb, int lim);
    in_valid <= 1'b0;
    wait_idle();
    write_register(CFG_MAP_KIND, CFG_DATA_W'(kind));
    write_register(CFG_KEY_BYTES, CFG_DATA_W'(kb));
    write_register(CFG_VALUE_BYTES, CFG_DATA_W'(vb));
    write_register(CFG_ENTRY_LIMIT, CFG_DATA_W'(lim));
    cfg_we <= 1'b0;
  endtask

  // reset settings: hash map, four key bytes, eight value bytes, 64 entries
  task automatic test_hash_basics();
    send_request(ACT_LOOKUP, 64'd0, 1'b0, 64'd0);
    send_request(ACT_NEXT, 64'd0, 1'b0, 64'd0);
    send_request(ACT_UPDATE, '1, 1'b0, '1);
    send_request(ACT_UPDATE, 64'd0, 1'b0, 64'd0);
    // upper key bytes are ignored
    send_request(ACT_LOOKUP, 64'h1234_5678_FFFF_FFFF, 1'b0, 64'd0);
    send_request(ACT_UPDATE, 64'h0000_0001_0000_0000, 1'b0, 64'hA5A5_A5A5_A5A5_A5A5);
    send_request(ACT_UPDATE, 64'h0000_0000_0BAD_F00D, 1'b0, 64'h0123_4567_89AB_CDEF);
    send_request(ACT_NEXT, 64'hFFFF_FFFF, 1'b1, 64'd0);
    send_request(ACT_NEXT, 64'h0BAD_F00D, 1'b1, 64'd0);
    // unknown given key restarts the scan at slot zero
    send_request(ACT_NEXT, 64'h7777_7777, 1'b1, 64'd0);
    send_request(ACT_DELETE, 64'd0, 1'b0, 64'd0);
    send_request(ACT_DELETE, 64'd0, 1'b0, 64'd0);
  endtask

  // widths and limit below and above their ranges, full table, clear on rewrite
  task automatic test_hash_limits();
    set_config(KIND_HASH, 0, 0, 0);
    send_request(ACT_UPDATE, 64'hAB12, 1'b0, 64'hFFEE);
    send_request(ACT_UPDATE, 64'h34, 1'b0, 64'h1);
    send_request(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FF12, 1'b0, 64'd0);
    send_request(ACT_NEXT, 64'h12, 1'b1, 64'd0);
    set_config(KIND_HASH, 15, 15, 127);
    send_request(ACT_UPDATE, '1, 1'b0, 64'h8000_0000_0000_0001);
    send_request(ACT_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 64'd0);
    set_config(KIND_HASH, 15, 15, 127);
    send_request(ACT_LOOKUP, '1, 1'b0, 64'd0);
  endtask

  task automatic test_array_mode();
    set_config(KIND_ARRAY, 2, 15, 127);
    send_request(ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_0000, 1'b0, 64'd0);
    send_request(ACT_UPDATE, 64'hABCD_0000_0000_003F, 1'b0, '1);
    send_request(ACT_LOOKUP, 64'h3F, 1'b0, 64'd0);
    send_request(ACT_LOOKUP, 64'h40, 1'b0, 64'd0);
    send_request(ACT_UPDATE, 64'hFFFF, 1'b0, 64'h5);
    send_request(ACT_DELETE, 64'd0, 1'b0, 64'd0);
    send_request(ACT_NEXT, 64'h3F, 1'b1, 64'd0);
    send_request(ACT_NEXT, 64'h40, 1'b1, 64'd0);
    // index taken from four key bytes at most
    set_config(KIND_ARRAY, 8, 1, 1);
    send_request(ACT_LOOKUP, 64'h1_0000_0000, 1'b0, 64'd0);
    send_request(ACT_LOOKUP, 64'h1_0000, 1'b0, 64'd0);
    send_request(ACT_UPDATE, 64'd0, 1'b0, 64'h1FF);
    send_request(ACT_NEXT, 64'd0, 1'b1, 64'd0);
  endtask

  task automatic test_random_traffic();
    logic [63:0] pool [24];
    logic [63:0] key;
    logic [63:0] kmask;
    logic [1:0]  act;
    logic        kg;
    int          pool_n;
    int          phase;
    int          n;
    int          r;
    int          kb;
    int          vb;
    int          lim;
    for (phase = 0; phase < 14; phase++) begin
      case (phase)
        0: set_config(KIND_HASH, 8, 8, 64);
        1: set_config(KIND_ARRAY, 1, 1, 1);
        2: set_config(KIND_HASH, 1, 1, 3);
        3: set_config(KIND_ARRAY, 4, 8, 64);
        default: begin
          kb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
          vb = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
          r = $urandom_range(0, 7);
          if (r < 4) lim = $urandom_range(1, 8);
          else if (r < 6) lim = $urandom_range(9, 64);
          else if (r == 6) lim = 0;
          else lim = $urandom_range(64, 127);
          set_config(1'($urandom_range(0, 1)), kb, vb, lim);
        end
      endcase
      idle_on = (phase < 12) && (phase % 4 != 3);
      kmask = low_bytes_mask(key_width());
      pool_n = $urandom_range(2, 24);
      for (n = 0; n < pool_n; n++) pool[n] = rand_word();
      for (n = 0; n < 100; n++) begin
        r = $urandom_range(0, 99);
        if (r < 35) act = ACT_UPDATE;
        else if (r < 65) act = ACT_LOOKUP;
        else if (r < 80) act = ACT_DELETE;
        else act = ACT_NEXT;
        kg = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 9) == 0)
          key = rand_word();
        else if (act == ACT_NEXT && kg && $urandom_range(0, 2) == 0)
          key = last_following;
        else if (cur_kind == KIND_HASH)
          key = pool[$urandom_range(0, pool_n - 1)] ^ (rand_word() & ~kmask);
        else
          key = (64'($urandom_range(0, slot_limit() + 2)) & index_mask())
                | (rand_word() & ~index_mask());
        send_request(act, key, kg, rand_word());
      end
    end
  endtask

  // out_ready pacing: random-length low bursts between ready stretches
  initial begin : sink_pacing
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        hold = $urandom_range(0, 10);
      end else begin
        out_ready <= 1'b1;
        hold = $urandom_range(0, 20);
      end
    end
  end

  always @(posedge clk) begin : reply_check
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("reply word with nothing pending, status", 64'(out_status), 64'd0);
      end else begin
        want = pending_replies.pop_front();
        status_seen[want.status]++;
        if (out_status !== want.status)
          report_mismatch("status", 64'(out_status), 64'(want.status));
        if (out_found_value !== want.found_value)
          report_mismatch("found_value", out_found_value, want.found_value);
        if (out_following_key !== want.following_key)
          report_mismatch("following_key", out_following_key, want.following_key);
      end
      replies_checked++;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles with %0d replies pending", cycles,
             pending_replies.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : main_flow
    cur_kind = KIND_HASH;
    cur_kbytes = RST_KEY_BYTES;
    cur_vbytes = RST_VALUE_BYTES;
    cur_limit = RST_ENTRY_LIMIT;
    wipe_store();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_hash_basics();
    test_hash_limits();
    test_array_mode();
    test_random_traffic();
    in_valid <= 1'b0;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d request words through %0d register writes, %0d replies checked",
             items_sent, config_writes, replies_checked);
    $display("reply status mix: ok %0d, not found %0d, full %0d, invalid for array %0d",
             status_seen[STAT_OK], status_seen[STAT_NOT_FOUND], status_seen[STAT_FULL],
             status_seen[STAT_INVALID]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
